>>> hdl/hsfc_pkg.sv
`timescale 1ns / 1ps

package hsfc_pkg;

    localparam int DRIVES_DEF       = 8;
    localparam int TRACKS_DEF       = 77;
    localparam int SECTORS_DEF      = 32;
    localparam int SECTOR_BYTES_DEF = 137;

    localparam int TRK_W = 7;

    // Flag bits of a drive.
    localparam logic [7:0] F_RDA     = 8'h80;
    localparam logic [7:0] F_TRK0    = 8'h40;
    localparam logic [7:0] F_HEAD    = 8'h04;
    localparam logic [7:0] F_WEN     = 8'h01;
    localparam logic [7:0] SEL_FLAGS = 8'h1A;

    localparam logic [7:0] PTR_EMPTY = 8'hFF;
    localparam logic [7:0] SEC_NONE  = 8'hFF;
    localparam logic [7:0] NO_DRIVE  = 8'hFF;

    localparam logic [1:0] PORT_STAT = 2'd0;
    localparam logic [1:0] PORT_CTRL = 2'd1;
    localparam logic [1:0] PORT_DATA = 2'd2;

    localparam logic KIND_IN  = 1'b0;
    localparam logic KIND_OUT = 1'b1;

    typedef struct packed {
        logic [7:0]       flags;
        logic [7:0]       ptr;
        logic [7:0]       sec;
        logic [TRK_W-1:0] trk;
    } drv_t;

    localparam drv_t DRV_RESET = '{flags: 8'h00, ptr: PTR_EMPTY, sec: SEC_NONE, trk: '0};

    typedef struct packed {
        logic rd;
        logic wr;
    } drv_cmd_t;

    function automatic logic attached_of(input logic [3:0] d, input logic [7:0] mask);
        return (d < 4'd8) && mask[d[2:0]];
    endfunction

endpackage

>>> hdl/hard_sector_floppy_controller.sv
`timescale 1ns / 1ps
// An access may first need a flush of the written sector or a load of the sector under the head.
// One item is in work at a time; the next item can be taken in the cycle after the result is loaded
// into the output register. Reset: asynchronous, active low. After reset a clearing pass zeroes the
// written marks and the sector buffer first.
module hard_sector_floppy_controller #(
    parameter int DRIVES       = hsfc_pkg::DRIVES_DEF,
    parameter int TRACKS       = hsfc_pkg::TRACKS_DEF,
    parameter int SECTORS      = hsfc_pkg::SECTORS_DEF,
    parameter int SECTOR_BYTES = hsfc_pkg::SECTOR_BYTES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] wdata
    input  logic [2:0] s_axis_tuser,   // [0] kind, [2:1] port
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] read_data
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata
);
    import hsfc_pkg::*;

    localparam int DW      = (DRIVES > 1) ? $clog2(DRIVES) : 1;
    localparam int BUF_LEN = SECTOR_BYTES + 1;
    localparam int BW      = $clog2(BUF_LEN);
    localparam int ROWS    = DRIVES * TRACKS * SECTORS;
    localparam int RW      = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int IMG_LEN = ROWS * SECTOR_BYTES;
    localparam int IW      = (IMG_LEN > 1) ? $clog2(IMG_LEN) : 1;
    localparam int CLR_LEN = (ROWS > BUF_LEN) ? ROWS : BUF_LEN;
    localparam int CLW     = (CLR_LEN > 1) ? $clog2(CLR_LEN) : 1;

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_PRE_RD, ST_PRE_WB, ST_CHK_FL, ST_FL_RD, ST_FL_GOT,
        ST_ROWA, ST_ROWB, ST_BASE, ST_FILL, ST_COPY, ST_FL_END, ST_LOAD, ST_LD_END,
        ST_MAIN_RD, ST_MAIN_EX, ST_BUF_RD, ST_DONE
    } state_t;

    // Sequencer registers.
    state_t          state_reg, state_next;
    logic            kind_reg, kind_next;
    logic [1:0]      port_reg, port_next;
    logic [7:0]      wdata_reg, wdata_next;
    logic [3:0]      sel_reg, sel_next;
    logic [7:0]      mask_reg, mask_next;
    logic            dirty_reg, dirty_next;
    logic [DW-1:0]   dirty_drv_reg, dirty_drv_next;
    logic [DW-1:0]   job_drv_reg, job_drv_next;
    logic            job_load_reg, job_load_next;
    logic            then_main_reg, then_main_next;
    drv_t            ent_reg, ent_next;
    logic            place_reg, place_next;
    logic [RW-1:0]   row_reg, row_next;
    logic [IW-1:0]   base_reg, base_next;
    logic [7:0]      cnt_reg, cnt_next;
    logic [CLW-1:0]  clr_reg, clr_next;
    logic [7:0]      res_reg, res_next;
    logic            out_vld_reg, out_vld_next;
    logic [7:0]      out_data_reg, out_data_next;

    // Drive table port.
    drv_cmd_t        drv_cmd;
    logic [DW-1:0]   drv_raddr, drv_waddr;
    drv_t            drv_wdata, drv_rdata;

    // Sector buffer, disk image and per-sector written marks.
    logic [7:0]      buf_mem [BUF_LEN];
    logic [7:0]      buf_rd_reg;
    logic            buf_we, buf_re;
    logic [BW-1:0]   buf_waddr, buf_raddr;
    logic [7:0]      buf_wd;

    logic [7:0]      img_mem [IMG_LEN];
    logic [7:0]      img_rd_reg;
    logic            img_we, img_re;
    logic [IW-1:0]   img_waddr, img_raddr;
    logic [7:0]      img_wd;

    logic            mark_mem [ROWS];
    logic            mark_rd_reg;
    logic            mark_we, mark_re;
    logic [RW-1:0]   mark_waddr;
    logic            mark_wd;

    function automatic logic [TRK_W-1:0] trk_inc(input logic [TRK_W-1:0] t);
        return ({1'b0, t} < 8'(TRACKS - 1)) ? t + 1'b1 : TRK_W'(TRACKS - 1);
    endfunction

    function automatic logic [TRK_W-1:0] trk_dec(input logic [TRK_W-1:0] t);
        return (t != '0) ? t - 1'b1 : '0;
    endfunction

    hsfc_drv_store #(
        .DRIVES (DRIVES),
        .DRV_W  (DW)
    ) u_drv_store (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (drv_cmd),
        .raddr (drv_raddr),
        .waddr (drv_waddr),
        .wdata (drv_wdata),
        .rdata (drv_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (buf_we)
        begin
            buf_mem[buf_waddr] <= buf_wd;
        end
        if (buf_re)
        begin
            buf_rd_reg <= buf_mem[buf_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (img_we)
        begin
            img_mem[img_waddr] <= img_wd;
        end
        if (img_re)
        begin
            img_rd_reg <= img_mem[img_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mark_we)
        begin
            mark_mem[mark_waddr] <= mark_wd;
        end
        if (mark_re)
        begin
            mark_rd_reg <= mark_mem[row_reg];
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;

    always_comb
    begin
        logic          sel_vld;
        logic [3:0]    cur_d;
        logic [7:0]    ld_byte;
        drv_t          e;
        logic [TRK_W-1:0] t;

        state_next     = state_reg;
        kind_next      = kind_reg;
        port_next      = port_reg;
        wdata_next     = wdata_reg;
        sel_next       = sel_reg;
        mask_next      = cfg_we ? cfg_wdata : mask_reg;
        dirty_next     = dirty_reg;
        dirty_drv_next = dirty_drv_reg;
        job_drv_next   = job_drv_reg;
        job_load_next  = job_load_reg;
        then_main_next = then_main_reg;
        ent_next       = ent_reg;
        place_next     = place_reg;
        row_next       = row_reg;
        base_next      = base_reg;
        cnt_next       = cnt_reg;
        clr_next       = clr_reg;
        res_next       = res_reg;
        out_vld_next   = out_vld_reg && !m_axis_tready;
        out_data_next  = out_data_reg;

        drv_cmd   = '{rd: 1'b0, wr: 1'b0};
        drv_raddr = sel_reg[DW-1:0];
        drv_waddr = sel_reg[DW-1:0];
        drv_wdata = drv_rdata;
        buf_we    = 1'b0;
        buf_re    = 1'b0;
        buf_waddr = cnt_reg[BW-1:0];
        buf_raddr = cnt_reg[BW-1:0];
        buf_wd    = 8'h00;
        img_we    = 1'b0;
        img_re    = 1'b0;
        img_waddr = base_reg + IW'(cnt_reg - 8'd1);
        img_raddr = base_reg + IW'(cnt_reg);
        img_wd    = buf_rd_reg;
        mark_we   = 1'b0;
        mark_re   = 1'b0;
        mark_waddr = row_reg;
        mark_wd   = 1'b1;

        sel_vld = ({1'b0, sel_reg} < 5'(DRIVES));
        cur_d   = (port_reg == PORT_STAT && kind_reg == KIND_OUT) ? wdata_reg[3:0] : sel_reg;
        ld_byte = (place_reg && mark_rd_reg) ? img_rd_reg : 8'h00;
        e       = drv_rdata;
        t       = drv_rdata.trk;

        unique case (state_reg)
            ST_CLEAR:
            begin
                // Zero the written marks and the sector buffer, one entry a cycle.
                mark_we    = (32'(clr_reg) < ROWS);
                mark_waddr = RW'(clr_reg);
                mark_wd    = 1'b0;
                buf_we     = (32'(clr_reg) < BUF_LEN);
                buf_waddr  = BW'(clr_reg);
                if (clr_reg == CLW'(CLR_LEN - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end

            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    kind_next  = s_axis_tuser[0];
                    port_next  = s_axis_tuser[2:1];
                    wdata_next = s_axis_tdata;
                    res_next   = 8'h00;
                    case (s_axis_tuser[2:1])
                        PORT_STAT:
                        begin
                            if (s_axis_tuser[0] == KIND_OUT)
                            begin
                                state_next = ST_CHK_FL;
                            end
                            else if (sel_vld)
                            begin
                                state_next = ST_MAIN_RD;
                            end
                            else
                            begin
                                res_next   = NO_DRIVE;
                                state_next = ST_DONE;
                            end
                        end
                        PORT_CTRL:
                        begin
                            if (s_axis_tuser[0] == KIND_IN)
                            begin
                                state_next = ST_CHK_FL;
                            end
                            else if (!sel_vld)
                            begin
                                state_next = ST_DONE;
                            end
                            else if (s_axis_tdata[1:0] != 2'b00)
                            begin
                                state_next = ST_PRE_RD;
                            end
                            else
                            begin
                                state_next = ST_CHK_FL;
                            end
                        end
                        PORT_DATA:
                        begin
                            state_next = (sel_vld && attached_of(sel_reg, mask_reg)) ?
                                         ST_MAIN_RD : ST_DONE;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_PRE_RD:
            begin
                drv_cmd.rd = 1'b1;
                state_next = ST_PRE_WB;
            end

            ST_PRE_WB:
            begin
                // The first step moves the head before any flush sees the track.
                e.trk      = wdata_reg[0] ? trk_inc(t) : trk_dec(t);
                drv_wdata  = e;
                drv_cmd.wr = 1'b1;
                state_next = ST_CHK_FL;
            end

            ST_CHK_FL:
            begin
                if (dirty_reg)
                begin
                    then_main_next = 1'b1;
                    state_next     = ST_FL_RD;
                end
                else
                begin
                    state_next = ST_MAIN_RD;
                end
            end

            ST_FL_RD:
            begin
                drv_raddr    = dirty_drv_reg;
                drv_cmd.rd   = 1'b1;
                job_drv_next = dirty_drv_reg;
                state_next   = ST_FL_GOT;
            end

            ST_FL_GOT:
            begin
                ent_next      = drv_rdata;
                job_load_next = 1'b0;
                state_next    = ST_ROWA;
            end

            ST_ROWA:
            begin
                row_next   = RW'(job_drv_reg) * RW'(TRACKS) + RW'(ent_reg.trk);
                place_next = ({1'b0, ent_reg.trk} < 8'(TRACKS)) &&
                             (ent_reg.sec < 8'(SECTORS)) &&
                             (job_load_reg || attached_of(4'(job_drv_reg), mask_reg));
                state_next = ST_ROWB;
            end

            ST_ROWB:
            begin
                row_next   = row_reg * RW'(SECTORS) + RW'(ent_reg.sec);
                state_next = ST_BASE;
            end

            ST_BASE:
            begin
                base_next = IW'(row_reg) * IW'(SECTOR_BYTES);
                cnt_next  = 8'd0;
                if (job_load_reg)
                begin
                    mark_re    = place_reg;
                    state_next = ST_LOAD;
                end
                else if ({1'b0, ent_reg.ptr} < 9'(BUF_LEN))
                begin
                    cnt_next   = ent_reg.ptr;
                    state_next = ST_FILL;
                end
                else
                begin
                    state_next = ST_COPY;
                end
            end

            ST_FILL:
            begin
                buf_we = 1'b1;
                if (cnt_reg == 8'(BUF_LEN - 1))
                begin
                    cnt_next   = 8'd0;
                    state_next = ST_COPY;
                end
                else
                begin
                    cnt_next = cnt_reg + 8'd1;
                end
            end

            ST_COPY:
            begin
                // The buffer read is registered, so the image write of each byte follows in the cycle after its read.
                buf_re = (cnt_reg < 8'(SECTOR_BYTES));
                img_we = (cnt_reg != 8'd0) && place_reg;
                if (cnt_reg == 8'(SECTOR_BYTES))
                begin
                    state_next = ST_FL_END;
                end
                else
                begin
                    cnt_next = cnt_reg + 8'd1;
                end
            end

            ST_FL_END:
            begin
                mark_we         = place_reg;
                drv_waddr       = job_drv_reg;
                drv_wdata       = ent_reg;
                drv_wdata.flags = ent_reg.flags & ~F_WEN;
                drv_wdata.ptr   = PTR_EMPTY;
                drv_cmd.wr      = 1'b1;
                dirty_next      = 1'b0;
                state_next      = then_main_reg ? ST_MAIN_RD : ST_DONE;
            end

            ST_LOAD:
            begin
                img_re    = (cnt_reg < 8'(SECTOR_BYTES)) && place_reg;
                buf_we    = (cnt_reg != 8'd0);
                buf_waddr = BW'(cnt_reg - 8'd1);
                buf_wd    = ld_byte;
                if (cnt_reg == 8'd1)
                begin
                    res_next = ld_byte;
                end
                if (cnt_reg == 8'(SECTOR_BYTES))
                begin
                    state_next = ST_LD_END;
                end
                else
                begin
                    cnt_next = cnt_reg + 8'd1;
                end
            end

            ST_LD_END:
            begin
                // The spare byte after the sector is always zero after a load.
                buf_we        = 1'b1;
                buf_waddr     = BW'(SECTOR_BYTES);
                drv_waddr     = job_drv_reg;
                drv_wdata     = ent_reg;
                drv_wdata.ptr = 8'd1;
                drv_cmd.wr    = 1'b1;
                state_next    = ST_DONE;
            end

            ST_MAIN_RD:
            begin
                sel_next = cur_d;
                if ({1'b0, cur_d} < 5'(DRIVES))
                begin
                    drv_raddr  = cur_d[DW-1:0];
                    drv_cmd.rd = 1'b1;
                    state_next = ST_MAIN_EX;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end

            ST_MAIN_EX:
            begin
                state_next = ST_DONE;
                case (port_reg)
                    PORT_STAT:
                    begin
                        if (kind_reg == KIND_IN)
                        begin
                            res_next = ~drv_rdata.flags;
                        end
                        else
                        begin
                            e.sec      = SEC_NONE;
                            e.ptr      = PTR_EMPTY;
                            e.flags    = wdata_reg[7] ? 8'h00 :
                                         (SEL_FLAGS | ((t == '0) ? F_TRK0 : 8'h00));
                            drv_wdata  = e;
                            drv_cmd.wr = 1'b1;
                        end
                    end
                    PORT_CTRL:
                    begin
                        if (kind_reg == KIND_IN)
                        begin
                            if ((drv_rdata.flags & F_HEAD) != 8'h00)
                            begin
                                e.sec      = (drv_rdata.sec >= 8'(SECTORS - 1)) ? 8'd0 :
                                             drv_rdata.sec + 8'd1;
                                e.ptr      = PTR_EMPTY;
                                res_next   = {2'b11, e.sec[4:0], 1'b0};
                                drv_wdata  = e;
                                drv_cmd.wr = 1'b1;
                            end
                        end
                        else
                        begin
                            if (wdata_reg[0] && wdata_reg[1])
                            begin
                                t = trk_dec(t);
                            end
                            e.trk = t;
                            if (wdata_reg[1:0] != 2'b00)
                            begin
                                e.sec   = SEC_NONE;
                                e.ptr   = PTR_EMPTY;
                                e.flags = (t == '0) ? (e.flags | F_TRK0) : (e.flags & ~F_TRK0);
                            end
                            if (wdata_reg[2])
                            begin
                                e.flags = e.flags | F_HEAD | F_RDA;
                            end
                            if (wdata_reg[3])
                            begin
                                e.flags = e.flags & ~(F_HEAD | F_RDA);
                                e.sec   = SEC_NONE;
                                e.ptr   = PTR_EMPTY;
                            end
                            if (wdata_reg[7])
                            begin
                                e.ptr   = 8'd0;
                                e.flags = e.flags | F_WEN;
                            end
                            drv_wdata  = e;
                            drv_cmd.wr = 1'b1;
                        end
                    end
                    PORT_DATA:
                    begin
                        if (kind_reg == KIND_IN)
                        begin
                            if ({1'b0, drv_rdata.ptr} < 9'(BUF_LEN))
                            begin
                                e.ptr      = drv_rdata.ptr + 8'd1;
                                drv_wdata  = e;
                                drv_cmd.wr = 1'b1;
                                buf_re     = 1'b1;
                                buf_raddr  = drv_rdata.ptr[BW-1:0];
                                state_next = ST_BUF_RD;
                            end
                            else
                            begin
                                // Buffer empty: load the sector under the head.
                                ent_next      = drv_rdata;
                                job_drv_next  = sel_reg[DW-1:0];
                                job_load_next = 1'b1;
                                state_next    = ST_ROWA;
                            end
                        end
                        else if ((drv_rdata.flags & F_WEN) != 8'h00)
                        begin
                            if ({1'b0, drv_rdata.ptr} < 9'(SECTOR_BYTES))
                            begin
                                buf_we         = 1'b1;
                                buf_waddr      = drv_rdata.ptr[BW-1:0];
                                buf_wd         = wdata_reg;
                                dirty_next     = 1'b1;
                                dirty_drv_next = sel_reg[DW-1:0];
                                e.ptr          = drv_rdata.ptr + 8'd1;
                                drv_wdata      = e;
                                drv_cmd.wr     = 1'b1;
                            end
                            else if (dirty_reg && dirty_drv_reg == sel_reg[DW-1:0])
                            begin
                                then_main_next = 1'b0;
                                state_next     = ST_FL_RD;
                            end
                            else
                            begin
                                e.flags    = drv_rdata.flags & ~F_WEN;
                                e.ptr      = PTR_EMPTY;
                                drv_wdata  = e;
                                drv_cmd.wr = 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end

            ST_BUF_RD:
            begin
                res_next   = buf_rd_reg;
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (!out_vld_reg || m_axis_tready)
                begin
                    out_vld_next  = 1'b1;
                    out_data_next = (kind_reg == KIND_IN) ? res_reg : 8'h00;
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            kind_reg      <= KIND_IN;
            port_reg      <= PORT_STAT;
            wdata_reg     <= 8'h00;
            sel_reg       <= 4'd0;
            mask_reg      <= 8'hFF;
            dirty_reg     <= 1'b0;
            dirty_drv_reg <= '0;
            job_drv_reg   <= '0;
            job_load_reg  <= 1'b0;
            then_main_reg <= 1'b0;
            ent_reg       <= DRV_RESET;
            place_reg     <= 1'b0;
            row_reg       <= '0;
            base_reg      <= '0;
            cnt_reg       <= 8'd0;
            clr_reg       <= '0;
            res_reg       <= 8'h00;
            out_vld_reg   <= 1'b0;
            out_data_reg  <= 8'h00;
        end
        else
        begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            port_reg      <= port_next;
            wdata_reg     <= wdata_next;
            sel_reg       <= sel_next;
            mask_reg      <= mask_next;
            dirty_reg     <= dirty_next;
            dirty_drv_reg <= dirty_drv_next;
            job_drv_reg   <= job_drv_next;
            job_load_reg  <= job_load_next;
            then_main_reg <= then_main_next;
            ent_reg       <= ent_next;
            place_reg     <= place_next;
            row_reg       <= row_next;
            base_reg      <= base_next;
            cnt_reg       <= cnt_next;
            clr_reg       <= clr_next;
            res_reg       <= res_next;
            out_vld_reg   <= out_vld_next;
            out_data_reg  <= out_data_next;
        end
    end

endmodule

>>> hdl/hsfc_drv_store.sv
`timescale 1ns / 1ps

module hsfc_drv_store #(
    parameter int DRIVES = hsfc_pkg::DRIVES_DEF,
    parameter int DRV_W  = (DRIVES > 1) ? $clog2(DRIVES) : 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  hsfc_pkg::drv_cmd_t cmd,
    input  logic [DRV_W-1:0]   raddr,
    input  logic [DRV_W-1:0]   waddr,
    input  hsfc_pkg::drv_t     wdata,
    output hsfc_pkg::drv_t     rdata
);
    import hsfc_pkg::*;

    // Entries never written read as their reset value through the valid bits.
    drv_t              mem [DRIVES];
    logic [DRIVES-1:0] vld_reg;
    drv_t              q_reg;
    logic              qv_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr)
        begin
            mem[waddr] <= wdata;
        end
        if (cmd.rd)
        begin
            q_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            qv_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.rd)
            begin
                qv_reg <= vld_reg[raddr] || (cmd.wr && waddr == raddr && 1'b0);
            end
            if (cmd.wr)
            begin
                vld_reg[waddr] <= 1'b1;
            end
        end
    end

    assign rdata = qv_reg ? q_reg : DRV_RESET;

endmodule
